### hw/rtl/b2s_pkg.sv
// Package: BLAKE2s constants, sigma table and helper functions.
package b2s_pkg;

    localparam int BLOCK_BYTES_DEF = 64;
    localparam logic [5:0] DIGEST_LEN_RESET = 6'd32;
    localparam logic [31:0] PARAM_BASE = 32'h0101_0000;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef logic [31:0] word_t;

    function automatic word_t iv_word(input logic [2:0] i);
        word_t w;
        w = 32'h0;
        case (i)
            3'd0: w = 32'h6A09E667;
            3'd1: w = 32'hBB67AE85;
            3'd2: w = 32'h3C6EF372;
            3'd3: w = 32'hA54FF53A;
            3'd4: w = 32'h510E527F;
            3'd5: w = 32'h9B05688C;
            3'd6: w = 32'h1F83D9AB;
            3'd7: w = 32'h5BE0CD19;
            default: w = 32'h0;
        endcase
        return w;
    endfunction

    // Sigma table: 10 rounds x 16 nibbles, entry 0 in the low nibble.
    localparam logic [63:0] SIGMA [10] = '{
        64'hFEDCBA9876543210,
        64'h357B20C16DF984AE,
        64'h491763EADF250C8B,
        64'h8F04A562EBCD1397,
        64'hD386CB1EFA427509,
        64'h91EF57D438B0A6C2,
        64'hB8293670A4DEF15C,
        64'hA2684F05931CE7BD,
        64'h5A417D2C803B9EF6,
        64'h0DC3E9BF5167482A
    };

    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
        logic [63:0] row;
        row = SIGMA[r];
        return row[k*4 +: 4];
    endfunction

    function automatic logic [5:0] eff_len(input logic [5:0] l);
        logic [5:0] e;
        e = l;
        if (l == 6'd0) e = 6'd1;
        else if (l > 6'd32) e = 6'd32;
        return e;
    endfunction

    typedef struct packed {
        logic       start;
        logic       final_blk;
    } cmp_ctl_t;

endpackage

### hw/rtl/blake2s_hash_engine.sv
// Top level: BLAKE2s byte-stream hash engine.
// Absorb beats are accepted while the 64-byte block buffer has room. An
// absorb beat that arrives with the buffer full first compresses the held
// block, so in_ready stays low until that is done (80 G calls, each two
// half-steps on one shared adder/rotate unit, then a fold of the result
// into the chain value). A finish beat compresses the zero-padded block
// the same way, then emits digest_length bytes (clamped to 1..32), one per
// output beat; input is held off until the last byte is taken. Writing
// digest_length restarts the message.
module blake2s_hash_engine
    import b2s_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] digest_byte,
    output logic [4:0] byte_index,
    output logic       last_byte,
    input  logic       cfg_we,
    input  logic [5:0] cfg_data
);

    localparam int FW = $clog2(BLOCK_BYTES) + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t      state_reg;
    word_t       h_reg [8];
    word_t       buf_mem [BLOCK_BYTES/4];
    logic [FW-1:0] fill_reg;
    logic [63:0] cnt_reg;
    logic [5:0]  len_reg;
    logic [4:0]  idx_reg;
    logic [7:0]  pend_byte_reg;
    word_t       m_w [16];
    word_t       h_new [8];
    cmp_ctl_t    ctl;
    logic        done;
    logic [5:0]  elen;
    logic        acc;

    assign elen = eff_len(len_reg);
    assign acc  = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // Form message words, zero above fill count
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            for (int k = 0; k < 4; k++)
                m_w[i][8*k +: 8] = ((i*4+k) < int'(fill_reg)) ? buf_mem[i][8*k +: 8] : 8'h0;
    end

    always_comb
    begin
        ctl.start = 1'b0;
        ctl.final_blk = 1'b0;
        if (acc && operation == OP_FINISH)
            ctl.start = 1'b1;
        if (acc && operation == OP_ABSORB && fill_reg == FW'(BLOCK_BYTES))
            ctl.start = 1'b1;
        ctl.final_blk = (operation == OP_FINISH);
    end

    b2s_round u_round (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .count(acc && operation == OP_FINISH ? cnt_reg + 64'(fill_reg)
                                             : cnt_reg + 64'(BLOCK_BYTES)),
        .h_in(h_reg), .m_in(m_w), .done(done), .h_out(h_new)
    );

    // Store absorbed bytes into their word lane
    always_ff @(posedge clk)
    begin
        if (acc && operation == OP_ABSORB && fill_reg != FW'(BLOCK_BYTES))
            buf_mem[fill_reg[FW-2:2]][8*fill_reg[1:0] +: 8] <= data_byte;
        else if (state_reg == ST_CMP && done)
            buf_mem[0][7:0] <= pend_byte_reg;
        if (acc) pend_byte_reg <= data_byte;
    end

    // Sequence the message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= DIGEST_LEN_RESET;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= iv_word(3'(i)) ^ ((i == 0) ? (PARAM_BASE | 32'd32) : 32'h0);
        end
        else if (cfg_we)
        begin
            len_reg  <= cfg_data;
            fill_reg <= '0;
            cnt_reg  <= '0;
            state_reg <= ST_IDLE;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= iv_word(3'(i)) ^
                    ((i == 0) ? (PARAM_BASE | 32'(eff_len(cfg_data))) : 32'h0);
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (acc)
                    begin
                        if (operation == OP_FINISH)
                        begin
                            cnt_reg <= cnt_reg + 64'(fill_reg);
                            state_reg <= ST_FIN;
                        end
                        else if (fill_reg == FW'(BLOCK_BYTES))
                        begin
                            cnt_reg <= cnt_reg + 64'(BLOCK_BYTES);
                            state_reg <= ST_CMP;
                        end
                        else
                            fill_reg <= fill_reg + FW'(1);
                    end
                ST_CMP:
                    if (done)
                    begin
                        for (int i = 0; i < 8; i++) h_reg[i] <= h_new[i];
                        fill_reg <= FW'(1);
                        state_reg <= ST_IDLE;
                    end
                ST_FIN:
                    if (done)
                    begin
                        for (int i = 0; i < 8; i++) h_reg[i] <= h_new[i];
                        idx_reg <= '0;
                        state_reg <= ST_OUT;
                    end
                ST_OUT:
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 5'd1;
                        if (6'(idx_reg) + 6'd1 == elen)
                        begin
                            fill_reg <= '0;
                            cnt_reg  <= '0;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= iv_word(3'(i)) ^
                                    ((i == 0) ? (PARAM_BASE | 32'(elen)) : 32'h0);
                            state_reg <= ST_IDLE;
                        end
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Drive the digest beat
    assign out_valid   = (state_reg == ST_OUT);
    assign byte_index  = idx_reg;
    assign digest_byte = h_reg[idx_reg[4:2]][8*idx_reg[1:0] +: 8];
    assign last_byte   = (6'(idx_reg) + 6'd1 == elen);

endmodule

### hw/rtl/b2s_round.sv
// Shared G-step unit: sequences 80 G calls, each as 2 half-steps.
module b2s_round
    import b2s_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmp_ctl_t     ctl,
    input  logic [63:0]  count,
    input  word_t        h_in [8],
    input  word_t        m_in [16],
    output logic         done,
    output word_t        h_out [8]
);

    word_t v_reg [16];
    logic       busy_reg;
    logic       done_reg;
    logic [3:0] rnd_reg;
    logic [2:0] g_reg;
    logic       half_reg;

    logic [3:0] ia, ib, ic, id;
    word_t x, y, a1, d1, c1, b1;

    // Select column or diagonal indices for the current G call
    always_comb
    begin
        case (g_reg)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
    end

    // Half of G: first uses rotations 16/12, second 8/7
    always_comb
    begin
        x  = m_in[sigma(rnd_reg, {g_reg, half_reg})];
        a1 = v_reg[ia] + v_reg[ib] + x;
        y  = v_reg[id] ^ a1;
        d1 = half_reg ? {y[7:0], y[31:8]} : {y[15:0], y[31:16]};
        c1 = v_reg[ic] + d1;
        b1 = half_reg ? ((v_reg[ib] ^ c1) >> 7 | (v_reg[ib] ^ c1) << 25)
                      : ((v_reg[ib] ^ c1) >> 12 | (v_reg[ib] ^ c1) << 20);
    end

    // Advance the step counters; flag done once the last half-step has landed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= 4'd0;
            g_reg    <= 3'd0;
            half_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            rnd_reg  <= 4'd0;
            g_reg    <= 3'd0;
            half_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            done_reg <= half_reg && g_reg == 3'd7 && rnd_reg == 4'd9;
            half_reg <= ~half_reg;
            if (half_reg)
            begin
                g_reg <= g_reg + 3'd1;
                if (g_reg == 3'd7)
                begin
                    if (rnd_reg == 4'd9) busy_reg <= 1'b0;
                    rnd_reg <= rnd_reg + 4'd1;
                end
            end
        end
        else
            done_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_in[i];
            for (int i = 8; i < 12; i++)
                v_reg[i] <= iv_word(3'(i - 8));
            v_reg[12] <= iv_word(3'd4) ^ count[31:0];
            v_reg[13] <= iv_word(3'd5) ^ count[63:32];
            v_reg[14] <= iv_word(3'd6) ^ {32{ctl.final_blk}};
            v_reg[15] <= iv_word(3'd7);
        end
        else if (busy_reg)
        begin
            v_reg[ia] <= a1;
            v_reg[ib] <= b1;
            v_reg[ic] <= c1;
            v_reg[id] <= d1;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            h_out[i] = h_in[i] ^ v_reg[i] ^ v_reg[i+8];
    end

endmodule
